[design/ase_pkg.sv]
package ase_pkg;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_CMP = 4'd2;
  localparam logic [3:0] OP_MOV = 4'd3;
  localparam logic [3:0] OP_AND = 4'd4;
  localparam logic [3:0] OP_ORR = 4'd5;
  localparam logic [3:0] OP_EOR = 4'd6;
  localparam logic [3:0] OP_LDR = 4'd7;
  localparam logic [3:0] OP_STR = 4'd8;
  localparam logic [3:0] OP_LSL = 4'd9;
  localparam logic [3:0] OP_LSR = 4'd10;
  localparam logic [3:0] OP_MVN = 4'd11;
  localparam logic [3:0] OP_BEQ = 4'd12;

  localparam logic [2:0] CC_AL = 3'd0;
  localparam logic [2:0] CC_GT = 3'd1;
  localparam logic [2:0] CC_GE = 3'd2;
  localparam logic [2:0] CC_LT = 3'd3;
  localparam logic [2:0] CC_LE = 3'd4;
  localparam logic [2:0] CC_EQ = 3'd5;
  localparam logic [2:0] CC_NE = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_COND   = 2'd1;
  localparam logic [1:0] ST_BADMEM = 2'd2;
  localparam logic [1:0] ST_UNSUP  = 2'd3;

  localparam logic [31:0] MEM_BASE = 32'h0000_0100;

  typedef logic [3:0] nzcv_t;

  function automatic nzcv_t nzcv(input logic [31:0] r, input logic [31:0] a,
                                 input logic [31:0] b, input logic sub);
    logic c;
    logic v;
    if (sub) begin
      c = (a >= b);
      v = (a[31] != b[31]) && (r[31] != a[31]);
    end else begin
      c = (r < a) || (r < b);
      v = (a[31] == b[31]) && (r[31] != a[31]);
    end
    return {r[31], (r == 32'd0), c, v};
  endfunction

  function automatic logic cond_holds(input logic [2:0] cond, input nzcv_t f);
    logic n;
    logic z;
    logic v;
    logic ok;
    n = f[3];
    z = f[2];
    v = f[0];
    case (cond)
      CC_AL:   ok = 1'b1;
      CC_GT:   ok = !z && (n == v);
      CC_GE:   ok = (n == v);
      CC_LT:   ok = (n != v);
      CC_LE:   ok = z || (n != v);
      CC_EQ:   ok = z;
      CC_NE:   ok = !z;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

[design/ase_ram.sv]
module ase_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/arm_subset_execute_unit.sv]
// channel | dir | signals                               | word
// in      | in  | in_tvalid/in_tready/in_tdata/in_tuser | one pre-decoded instruction
// out     | out | out_tvalid/out_tready/out_tdata       | one execution result
// One word per cycle sustained while out_tready stays high; a word passes the stage 1, stage 2 and output registers.
// Stage 1 reads the register file, stage 2 reads data memory and executes, stage 3 holds
// the result. Later stages forward writes back so dependent words need no bubbles.
// After reset, a sweep writes zero to every entry of both memories; in_tready is low then.
// A stalled output backs up through the stages; each stage holds its word until it moves.
module arm_subset_execute_unit #(
  parameter int NUM_REGS  = 12,
  parameter int MEM_WORDS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cond[2:0] set_flags[3] reg_a[7:4] reg_b[11:8] op2_is_imm[12] op2_reg[16:13]
  // immediate[48:17] mem_indirect[49] label_known[50] current_pc[66:51]
  input  logic [71:0] in_tdata,
  // kind[3:0]
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // next_pc[15:0] status[17:16] flags_nzcv[21:18] result_value[53:22] branch_taken[54]
  output logic [55:0] out_tdata
);

  localparam int RAW     = $clog2(NUM_REGS);
  localparam int DAW     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int CLR_LEN = (NUM_REGS > MEM_WORDS) ? NUM_REGS : MEM_WORDS;
  localparam int CW      = $clog2(CLR_LEN + 1);

  // input fields
  logic [3:0]  in_kind;
  logic [2:0]  in_cond;
  logic        in_set_flags;
  logic [3:0]  in_reg_a;
  logic [3:0]  in_reg_b;
  logic        in_op2_is_imm;
  logic [3:0]  in_op2_reg;
  logic [31:0] in_immediate;
  logic        in_mem_indirect;
  logic        in_label_known;
  logic [15:0] in_current_pc;

  assign in_kind         = in_tuser;
  assign in_cond         = in_tdata[2:0];
  assign in_set_flags    = in_tdata[3];
  assign in_reg_a        = in_tdata[7:4];
  assign in_reg_b        = in_tdata[11:8];
  assign in_op2_is_imm   = in_tdata[12];
  assign in_op2_reg      = in_tdata[16:13];
  assign in_immediate    = in_tdata[48:17];
  assign in_mem_indirect = in_tdata[49];
  assign in_label_known  = in_tdata[50];
  assign in_current_pc   = in_tdata[66:51];

  // clearing sweep
  logic          clearing_r;
  logic [CW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == CW'(CLR_LEN - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + CW'(1);
    end
  end

  // handshake
  logic s1_valid_r;
  logic s2_valid_r;
  logic out_valid_r;
  logic s2_exec;
  logic s1_adv;
  logic in_fire;

  assign s2_exec   = s2_valid_r && (!out_valid_r || out_tready);
  assign s1_adv    = s1_valid_r && (!s2_valid_r || s2_exec);
  assign in_tready = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;

  // stage 1 registers
  logic [3:0]  s1_kind_r;
  logic [2:0]  s1_cond_r;
  logic        s1_s_r;
  logic [3:0]  s1_ra_r;
  logic [3:0]  s1_rb_r;
  logic [3:0]  s1_p1_r;
  logic        s1_imm_sel_r;
  logic [31:0] s1_imm_r;
  logic        s1_ind_r;
  logic        s1_label_r;
  logic [15:0] s1_pc_r;
  logic        byp_en_r;
  logic [3:0]  byp_idx_r;
  logic [31:0] byp_data_r;

  // stage 2 registers
  logic [3:0]     s2_kind_r;
  logic [2:0]     s2_cond_r;
  logic           s2_s_r;
  logic [3:0]     s2_ra_r;
  logic [31:0]    s2_a_r;
  logic [31:0]    s2_b_r;
  logic [31:0]    s2_st_r;
  logic [31:0]    s2_imm_r;
  logic           s2_ind_r;
  logic           s2_label_r;
  logic [15:0]    s2_pc_r;
  logic           s2_mok_r;
  logic [DAW-1:0] s2_midx_r;
  logic           s2_dbyp_r;
  logic [31:0]    s2_dbyp_data_r;

  ase_pkg::nzcv_t flags_r;
  ase_pkg::nzcv_t flags_nxt;
  logic [55:0]    out_data_r;

  // writeback from stage 2
  logic        wb_en;
  logic [31:0] wb_data;
  logic        dm_we;

  // register file, two read copies
  logic [3:0]     p1_sel;
  logic           rf_we;
  logic [RAW-1:0] rf_waddr;
  logic [31:0]    rf_wdata;
  logic [31:0]    rf0_q;
  logic [31:0]    rf1_q;

  assign p1_sel   = (in_kind == ase_pkg::OP_STR) ? in_reg_a : in_op2_reg;
  assign rf_we    = clearing_r ? (clr_cnt_r < CW'(NUM_REGS)) : wb_en;
  assign rf_waddr = clearing_r ? RAW'(clr_cnt_r) : RAW'(s2_ra_r);
  assign rf_wdata = clearing_r ? 32'd0 : wb_data;

  ase_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf0 (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_fire),
    .raddr (RAW'(in_reg_b)),
    .rdata (rf0_q)
  );

  ase_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf1 (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_fire),
    .raddr (RAW'(p1_sel)),
    .rdata (rf1_q)
  );

  // stage 1 operand resolution
  logic           rb_ok;
  logic           p1_ok;
  logic [31:0]    a_fwd;
  logic [31:0]    p1_fwd;
  logic [31:0]    b_val;
  logic [31:0]    maddr;
  logic [31:0]    mdiff;
  logic           m_ok;
  logic [DAW-1:0] m_idx;

  assign rb_ok = 6'(s1_rb_r) < 6'(NUM_REGS);
  assign p1_ok = 6'(s1_p1_r) < 6'(NUM_REGS);

  always_comb begin
    if (!rb_ok) begin
      a_fwd = 32'd0;
    end else if (wb_en && (s2_ra_r == s1_rb_r)) begin
      a_fwd = wb_data;
    end else if (byp_en_r && (byp_idx_r == s1_rb_r)) begin
      a_fwd = byp_data_r;
    end else begin
      a_fwd = rf0_q;
    end
    if (!p1_ok) begin
      p1_fwd = 32'd0;
    end else if (wb_en && (s2_ra_r == s1_p1_r)) begin
      p1_fwd = wb_data;
    end else if (byp_en_r && (byp_idx_r == s1_p1_r)) begin
      p1_fwd = byp_data_r;
    end else begin
      p1_fwd = rf1_q;
    end
  end

  assign b_val = s1_imm_sel_r ? s1_imm_r : p1_fwd;
  assign maddr = s1_ind_r ? a_fwd : s1_imm_r;
  assign mdiff = maddr - ase_pkg::MEM_BASE;
  assign m_ok  = (maddr >= ase_pkg::MEM_BASE) && (maddr[1:0] == 2'b00) &&
                 (mdiff[31:2] < 30'(MEM_WORDS));
  assign m_idx = mdiff[DAW+1:2];

  // data memory
  logic           dm_wr;
  logic [DAW-1:0] dm_waddr;
  logic [31:0]    dm_wdata;
  logic [31:0]    dm_q;

  assign dm_wr    = clearing_r ? (clr_cnt_r < CW'(MEM_WORDS)) : dm_we;
  assign dm_waddr = clearing_r ? DAW'(clr_cnt_r) : s2_midx_r;
  assign dm_wdata = clearing_r ? 32'd0 : s2_st_r;

  ase_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dm (
    .clk   (clk),
    .we    (dm_wr),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (s1_adv),
    .raddr (m_idx),
    .rdata (dm_q)
  );

  // stage 2 execute
  logic        cond_ok;
  logic [31:0] res;
  logic [1:0]  status;
  logic        taken;
  logic [15:0] npc;
  logic        rwr;
  logic        mwr;
  logic [31:0] ld_val;
  logic [31:0] shifted;
  logic        ra_ok;

  assign cond_ok = ase_pkg::cond_holds(s2_cond_r, flags_r);
  assign ld_val  = s2_dbyp_r ? s2_dbyp_data_r : dm_q;
  assign ra_ok   = 6'(s2_ra_r) < 6'(NUM_REGS);

  always_comb begin
    if (s2_imm_r >= 32'd32) begin
      shifted = 32'd0;
    end else if (s2_kind_r == ase_pkg::OP_LSL) begin
      shifted = s2_a_r << s2_imm_r[4:0];
    end else begin
      shifted = s2_a_r >> s2_imm_r[4:0];
    end
  end

  always_comb begin
    res       = 32'd0;
    status    = ase_pkg::ST_OK;
    taken     = 1'b0;
    npc       = s2_pc_r + 16'd1;
    rwr       = 1'b0;
    mwr       = 1'b0;
    flags_nxt = flags_r;
    if (!cond_ok) begin
      status = ase_pkg::ST_COND;
    end else begin
      case (s2_kind_r)
        ase_pkg::OP_ADD, ase_pkg::OP_AND, ase_pkg::OP_ORR, ase_pkg::OP_EOR: begin
          case (s2_kind_r)
            ase_pkg::OP_ADD: res = s2_a_r + s2_b_r;
            ase_pkg::OP_AND: res = s2_a_r & s2_b_r;
            ase_pkg::OP_ORR: res = s2_a_r | s2_b_r;
            default:         res = s2_a_r ^ s2_b_r;
          endcase
          rwr = 1'b1;
          if (s2_s_r) begin
            flags_nxt = ase_pkg::nzcv(res, s2_a_r, s2_b_r, 1'b0);
          end
        end
        ase_pkg::OP_SUB: begin
          res = s2_a_r - s2_b_r;
          rwr = 1'b1;
          if (s2_s_r) begin
            flags_nxt = ase_pkg::nzcv(res, s2_a_r, s2_b_r, 1'b1);
          end
        end
        ase_pkg::OP_CMP: begin
          flags_nxt = ase_pkg::nzcv(s2_a_r - s2_b_r, s2_a_r, s2_b_r, 1'b1);
        end
        ase_pkg::OP_MOV, ase_pkg::OP_MVN: begin
          res = (s2_kind_r == ase_pkg::OP_MOV) ? s2_b_r : ~s2_b_r;
          rwr = 1'b1;
          if (s2_s_r) begin
            flags_nxt = ase_pkg::nzcv(res, s2_b_r, 32'd0, 1'b0);
          end
        end
        ase_pkg::OP_LDR: begin
          if (!s2_mok_r) begin
            status = ase_pkg::ST_BADMEM;
          end else begin
            res = ld_val;
            rwr = 1'b1;
            if (s2_s_r && !s2_ind_r) begin
              flags_nxt = ase_pkg::nzcv(res, res, 32'd0, 1'b0);
            end
          end
        end
        ase_pkg::OP_STR: begin
          if (!s2_mok_r) begin
            status = ase_pkg::ST_BADMEM;
          end else begin
            res = s2_st_r;
            mwr = 1'b1;
            if (s2_s_r) begin
              flags_nxt = ase_pkg::nzcv(res, res, 32'd0, 1'b0);
            end
          end
        end
        ase_pkg::OP_LSL, ase_pkg::OP_LSR: begin
          res = shifted;
          rwr = 1'b1;
          if (s2_s_r) begin
            flags_nxt = ase_pkg::nzcv(res, s2_a_r, 32'd0, 1'b0);
          end
        end
        ase_pkg::OP_BEQ: begin
          if (flags_r[2] && s2_label_r) begin
            taken = 1'b1;
            npc   = s2_imm_r[15:0];
          end
        end
        default: begin
          status = ase_pkg::ST_UNSUP;
        end
      endcase
    end
  end

  assign wb_en   = s2_exec && rwr && ra_ok;
  assign wb_data = res;
  assign dm_we   = s2_exec && mwr;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (s2_exec) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_exec) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r    <= in_kind;
      s1_cond_r    <= in_cond;
      s1_s_r       <= in_set_flags;
      s1_ra_r      <= in_reg_a;
      s1_rb_r      <= in_reg_b;
      s1_p1_r      <= p1_sel;
      s1_imm_sel_r <= in_op2_is_imm;
      s1_imm_r     <= in_immediate;
      s1_ind_r     <= in_mem_indirect;
      s1_label_r   <= in_label_known;
      s1_pc_r      <= in_current_pc;
      byp_en_r     <= wb_en;
      byp_idx_r    <= s2_ra_r;
      byp_data_r   <= wb_data;
    end
    if (s1_adv) begin
      s2_kind_r      <= s1_kind_r;
      s2_cond_r      <= s1_cond_r;
      s2_s_r         <= s1_s_r;
      s2_ra_r        <= s1_ra_r;
      s2_a_r         <= a_fwd;
      s2_b_r         <= b_val;
      s2_st_r        <= p1_fwd;
      s2_imm_r       <= s1_imm_r;
      s2_ind_r       <= s1_ind_r;
      s2_label_r     <= s1_label_r;
      s2_pc_r        <= s1_pc_r;
      s2_mok_r       <= m_ok;
      s2_midx_r      <= m_idx;
      s2_dbyp_r      <= dm_we && (s2_midx_r == m_idx);
      s2_dbyp_data_r <= s2_st_r;
    end
    if (s2_exec) begin
      out_data_r <= {1'b0, taken, res, flags_nxt, status, npc};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready)
    else $error("word accepted during memory clear");

  a_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[17:16] != ase_pkg::ST_OK)) |-> (out_tdata[53:22] == 32'd0))
    else $error("nonzero result on failed word");

  a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[54]) |-> (out_tdata[17:16] == ase_pkg::ST_OK))
    else $error("branch taken with bad status");

  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_exec |=> (flags_r == $past(flags_r)))
    else $error("flags changed without execution");

endmodule

[bench/testbench.sv]
module testbench;

  localparam int NREGS      = 12;
  localparam int MWORDS     = 5;
  localparam int STALL_MAX  = 4000;
  localparam int DRAIN_WAIT = 10;
  localparam int NUM_RANDOM = 700;

  localparam logic [31:0] MEM_BASE = ase_pkg::MEM_BASE;

  typedef struct {
    logic [3:0]  kind;
    logic [2:0]  cond;
    logic        set_flags;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic        op2_is_imm;
    logic [3:0]  op2_reg;
    logic [31:0] immediate;
    logic        mem_indirect;
    logic        label_known;
    logic [15:0] current_pc;
  } instr_t;

  typedef struct {
    logic [15:0] next_pc;
    logic [1:0]  status;
    logic [3:0]  flags;
    logic [31:0] value;
    logic        taken;
  } outcome_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [3:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  arm_subset_execute_unit #(
    .NUM_REGS(NREGS),
    .MEM_WORDS(MWORDS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // predicted architectural state
  logic [31:0] gpr [NREGS];
  logic [31:0] dmem [MWORDS];
  logic [3:0]  nzcv_q;

  instr_t   instr_q[$];
  instr_t   cur_instr;
  outcome_t expected_log [int];
  int       issued;
  int       retired;
  int       accepted;
  int       errors;
  int       stall_cycles;
  int       send_idle_pct;
  int       ready_stall_pct;

  assign send_idle_pct   = ((accepted / 100) % 4 == 1) ? 67 :
                           ((accepted / 100) % 4 == 3) ? 36 : 0;
  assign ready_stall_pct = ((accepted / 100) % 4 == 2) ? 67 :
                           ((accepted / 100) % 4 == 3) ? 36 : 0;

  function automatic logic [31:0] rd_gpr(input logic [3:0] idx);
    return (idx < NREGS) ? gpr[idx] : 32'd0;
  endfunction

  function automatic void wr_gpr(input logic [3:0] idx, input logic [31:0] v);
    if (idx < NREGS) gpr[idx] = v;
  endfunction

  function automatic logic [3:0] arith_flags(input logic [31:0] r, input logic [31:0] a,
                                             input logic [31:0] b, input logic sub);
    logic c;
    logic v;
    if (sub) begin
      c = (a >= b);
      v = (a[31] ^ b[31]) & (r[31] ^ a[31]);
    end else begin
      c = (r < a) || (r < b);
      v = ~(a[31] ^ b[31]) & (r[31] ^ a[31]);
    end
    return {r[31], r == 32'd0, c, v};
  endfunction

  function automatic logic cond_pass(input logic [2:0] c);
    logic n;
    logic z;
    logic v;
    n = nzcv_q[3];
    z = nzcv_q[2];
    v = nzcv_q[0];
    case (c)
      ase_pkg::CC_AL: return 1'b1;
      ase_pkg::CC_GT: return !z && (n == v);
      ase_pkg::CC_GE: return n == v;
      ase_pkg::CC_LT: return n != v;
      ase_pkg::CC_LE: return z || (n != v);
      ase_pkg::CC_EQ: return z;
      ase_pkg::CC_NE: return !z;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic addr_ok(input logic [31:0] addr);
    return (addr >= MEM_BASE) && (addr[1:0] == 2'b00) && (((addr - MEM_BASE) >> 2) < MWORDS);
  endfunction

  function automatic outcome_t run_instr(input instr_t w);
    outcome_t    o;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    logic [31:0] addr;
    logic [31:0] slot;
    o.next_pc = w.current_pc + 16'd1;
    o.status  = ase_pkg::ST_OK;
    o.value   = 32'd0;
    o.taken   = 1'b0;
    a    = rd_gpr(w.reg_b);
    b    = w.op2_is_imm ? w.immediate : rd_gpr(w.op2_reg);
    addr = w.mem_indirect ? a : w.immediate;
    slot = (addr - MEM_BASE) >> 2;
    if (!cond_pass(w.cond)) begin
      o.status = ase_pkg::ST_COND;
    end else begin
      case (w.kind)
        ase_pkg::OP_ADD, ase_pkg::OP_AND, ase_pkg::OP_ORR, ase_pkg::OP_EOR: begin
          if (w.kind == ase_pkg::OP_ADD) r = a + b;
          else if (w.kind == ase_pkg::OP_AND) r = a & b;
          else if (w.kind == ase_pkg::OP_ORR) r = a | b;
          else r = a ^ b;
          wr_gpr(w.reg_a, r);
          o.value = r;
          if (w.set_flags) nzcv_q = arith_flags(r, a, b, 1'b0);
        end
        ase_pkg::OP_SUB: begin
          r = a - b;
          wr_gpr(w.reg_a, r);
          o.value = r;
          if (w.set_flags) nzcv_q = arith_flags(r, a, b, 1'b1);
        end
        ase_pkg::OP_CMP: begin
          nzcv_q = arith_flags(a - b, a, b, 1'b1);
        end
        ase_pkg::OP_MOV, ase_pkg::OP_MVN: begin
          r = (w.kind == ase_pkg::OP_MOV) ? b : ~b;
          wr_gpr(w.reg_a, r);
          o.value = r;
          if (w.set_flags) nzcv_q = arith_flags(r, b, 32'd0, 1'b0);
        end
        ase_pkg::OP_LDR: begin
          if (!addr_ok(addr)) begin
            o.status = ase_pkg::ST_BADMEM;
          end else begin
            r = dmem[slot];
            wr_gpr(w.reg_a, r);
            o.value = r;
            // indirect load leaves flags alone
            if (w.set_flags && !w.mem_indirect) nzcv_q = arith_flags(r, r, 32'd0, 1'b0);
          end
        end
        ase_pkg::OP_STR: begin
          if (!addr_ok(addr)) begin
            o.status = ase_pkg::ST_BADMEM;
          end else begin
            r = rd_gpr(w.reg_a);
            dmem[slot] = r;
            o.value = r;
            if (w.set_flags) nzcv_q = arith_flags(r, r, 32'd0, 1'b0);
          end
        end
        ase_pkg::OP_LSL, ase_pkg::OP_LSR: begin
          if (w.immediate >= 32) r = 32'd0;
          else if (w.kind == ase_pkg::OP_LSL) r = a << w.immediate[4:0];
          else r = a >> w.immediate[4:0];
          wr_gpr(w.reg_a, r);
          o.value = r;
          if (w.set_flags) nzcv_q = arith_flags(r, a, 32'd0, 1'b0);
        end
        ase_pkg::OP_BEQ: begin
          if (nzcv_q[2] && w.label_known) begin
            o.taken   = 1'b1;
            o.next_pc = w.immediate[15:0];
          end
        end
        default: begin
          o.status = ase_pkg::ST_UNSUP;
        end
      endcase
    end
    o.flags = nzcv_q;
    return o;
  endfunction

  function automatic instr_t mk(input logic [3:0] k, input logic [2:0] c, input logic s,
                                input logic [3:0] ra, input logic [3:0] rb,
                                input logic isimm, input logic [3:0] r2,
                                input logic [31:0] imm, input logic ind, input logic lbl);
    instr_t w;
    w.kind         = k;
    w.cond         = c;
    w.set_flags    = s;
    w.reg_a        = ra;
    w.reg_b        = rb;
    w.op2_is_imm   = isimm;
    w.op2_reg      = r2;
    w.immediate    = imm;
    w.mem_indirect = ind;
    w.label_known  = lbl;
    w.current_pc   = 16'($urandom);
    return w;
  endfunction

  function automatic logic [3:0] pick_reg();
    logic [3:0] r;
    if ($urandom_range(9) == 0) r = 4'($urandom_range(15, 12));
    else r = 4'($urandom_range(NREGS - 1));
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(64);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(9))
      0:       return MEM_BASE + 4 * MWORDS;
      1:       return MEM_BASE - 32'd4;
      2:       return MEM_BASE + 4 * $urandom_range(MWORDS - 1) + $urandom_range(3, 1);
      3:       return $urandom;
      default: return MEM_BASE + 4 * $urandom_range(MWORDS - 1);
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t w;
    if ($urandom_range(19) == 0) w.kind = 4'($urandom_range(15, 13));
    else w.kind = 4'($urandom_range(12));
    if ($urandom_range(1)) w.cond = ase_pkg::CC_AL;
    else w.cond = 3'($urandom_range(7));
    w.set_flags    = 1'($urandom_range(1));
    w.reg_a        = pick_reg();
    w.reg_b        = pick_reg();
    w.op2_reg      = pick_reg();
    w.op2_is_imm   = 1'($urandom_range(1));
    w.mem_indirect = 1'($urandom_range(1));
    w.label_known  = ($urandom_range(3) != 0);
    w.current_pc   = 16'($urandom);
    if (w.kind == ase_pkg::OP_LDR || w.kind == ase_pkg::OP_STR) w.immediate = pick_addr();
    else if ((w.kind == ase_pkg::OP_LSL || w.kind == ase_pkg::OP_LSR) &&
             $urandom_range(3) != 0)
      w.immediate = $urandom_range(31);
    else w.immediate = pick_value();
    return w;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    if (errors < 40)
      $display("word %0d: %s got %h, expected %h", retired, field, got, want);
    errors++;
  endtask

  // input driver and predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_log[issued] = run_instr(cur_instr);
        issued   <= issued + 1;
        accepted <= accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (instr_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_instr = instr_q.pop_front();
          in_tdata  <= {5'd0, cur_instr.current_pc, cur_instr.label_known,
                        cur_instr.mem_indirect, cur_instr.immediate, cur_instr.op2_reg,
                        cur_instr.op2_is_imm, cur_instr.reg_b, cur_instr.reg_a,
                        cur_instr.set_flags, cur_instr.cond};
          in_tuser  <= cur_instr.kind;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= ready_stall_pct);
      if (out_tvalid && out_tready) begin
        if (retired == issued) begin
          report("unexpected word", out_tdata[31:0], 32'd0);
        end else begin
          if (out_tdata[15:0] !== expected_log[retired].next_pc)
            report("next_pc", 32'(out_tdata[15:0]), 32'(expected_log[retired].next_pc));
          if (out_tdata[17:16] !== expected_log[retired].status)
            report("status", 32'(out_tdata[17:16]), 32'(expected_log[retired].status));
          if (out_tdata[21:18] !== expected_log[retired].flags)
            report("flags_nzcv", 32'(out_tdata[21:18]), 32'(expected_log[retired].flags));
          if (out_tdata[53:22] !== expected_log[retired].value)
            report("result_value", out_tdata[53:22], expected_log[retired].value);
          if (out_tdata[54] !== expected_log[retired].taken)
            report("branch_taken", 32'(out_tdata[54]), 32'(expected_log[retired].taken));
          retired <= retired + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    instr_t w;
    int     n;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    issued = 0;
    retired = 0;
    accepted = 0;
    errors = 0;
    stall_cycles = 0;
    for (int i = 0; i < NREGS; i++) gpr[i] = 32'd0;
    for (int i = 0; i < MWORDS; i++) dmem[i] = 32'd0;
    nzcv_q = 4'd0;

    // directed: flag extremes, every opcode, memory bounds, shifts, odd conditions
    instr_q.push_back(mk(ase_pkg::OP_MOV, ase_pkg::CC_AL, 1, 0, 0, 1, 0, 32'hFFFF_FFFF, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_MOV, ase_pkg::CC_AL, 0, 1, 0, 1, 0, 32'h7FFF_FFFF, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_ADD, ase_pkg::CC_AL, 1, 2, 0, 0, 1, 32'd0, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_ADD, ase_pkg::CC_GE, 1, 3, 1, 0, 1, 32'd0, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_SUB, ase_pkg::CC_LT, 1, 4, 1, 0, 0, 32'd0, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_CMP, ase_pkg::CC_AL, 0, 0, 0, 0, 0, 32'd0, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_BEQ, ase_pkg::CC_EQ, 0, 0, 0, 1, 0, 32'h0001_ABCD, 0, 1));
    instr_q.push_back(mk(ase_pkg::OP_BEQ, ase_pkg::CC_AL, 0, 0, 0, 1, 0, 32'h0000_1234, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_AND, ase_pkg::CC_NE, 1, 6, 0, 1, 0, 32'h8000_0000, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_ORR, ase_pkg::CC_AL, 1, 7, 1, 0, 0, 32'd0, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_EOR, ase_pkg::CC_LE, 1, 8, 0, 1, 0, 32'hFFFF_FFFF, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_MVN, ase_pkg::CC_GT, 1, 9, 0, 1, 0, 32'd0, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_STR, ase_pkg::CC_AL, 1, 0, 0, 1, 0, MEM_BASE, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_STR, ase_pkg::CC_AL, 0, 1, 0, 1, 0,
                         MEM_BASE + 4 * (MWORDS - 1), 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_MOV, ase_pkg::CC_AL, 0, 5, 0, 1, 0,
                         MEM_BASE + 32'h00C, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_STR, ase_pkg::CC_AL, 0, 2, 5, 1, 0, 32'd0, 1, 0));
    instr_q.push_back(mk(ase_pkg::OP_LDR, ase_pkg::CC_AL, 1, 10, 5, 1, 0, 32'd0, 1, 0));
    instr_q.push_back(mk(ase_pkg::OP_LDR, ase_pkg::CC_AL, 1, 11, 0, 1, 0, MEM_BASE, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_LDR, ase_pkg::CC_AL, 0, 3, 0, 1, 0,
                         MEM_BASE + 4 * MWORDS, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_LDR, ase_pkg::CC_AL, 0, 3, 0, 1, 0,
                         MEM_BASE + 32'd2, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_STR, ase_pkg::CC_AL, 0, 3, 0, 1, 0,
                         MEM_BASE - 32'd4, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_LSL, ase_pkg::CC_AL, 1, 3, 1, 1, 0, 32'd31, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_LSL, ase_pkg::CC_AL, 1, 3, 0, 1, 0, 32'd32, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_LSR, ase_pkg::CC_AL, 1, 4, 0, 1, 0, 32'hFFFF_FFFF, 0, 0));
    instr_q.push_back(mk(ase_pkg::OP_MOV, 3'd7, 0, 2, 0, 1, 0, 32'd5, 0, 0));
    instr_q.push_back(mk(4'd13, ase_pkg::CC_AL, 0, 0, 0, 0, 0, 32'd0, 0, 0));
    instr_q.push_back(mk(4'd15, 3'd7, 0, 0, 0, 0, 0, 32'd0, 0, 0));
    w = mk(ase_pkg::OP_ADD, ase_pkg::CC_AL, 1, 4'd15, 4'd14, 0, 4'd12, 32'd0, 0, 0);
    w.current_pc = 16'hFFFF;
    instr_q.push_back(w);

    n = 0;
    while (n < NUM_RANDOM) begin
      w = random_instr();
      // load an address into the base register ahead of most indirect accesses
      if ((w.kind == ase_pkg::OP_LDR || w.kind == ase_pkg::OP_STR) && w.mem_indirect &&
          $urandom_range(3) != 0) begin
        instr_q.push_back(mk(ase_pkg::OP_MOV, ase_pkg::CC_AL, 0, w.reg_b, 0, 1, 0,
                             pick_addr(), 0, 0));
        n++;
      end
      // compare a register with itself so the branch sees Z set
      if (w.kind == ase_pkg::OP_BEQ && $urandom_range(1)) begin
        instr_q.push_back(mk(ase_pkg::OP_CMP, ase_pkg::CC_AL, 0, 0, w.reg_b, 0, w.reg_b,
                             32'd0, 0, 0));
        n++;
      end
      instr_q.push_back(w);
      n++;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (!(instr_q.size() == 0 && !in_tvalid && issued == retired) &&
           stall_cycles < STALL_MAX);

    if (stall_cycles >= STALL_MAX) begin
      $display("arm_subset_execute_unit: mismatch");
    end else begin
      repeat (DRAIN_WAIT) @(negedge clk);
      if (errors == 0 && issued == retired) begin
        $display("arm_subset_execute_unit: match");
      end else begin
        $display("arm_subset_execute_unit: mismatch");
      end
    end
    $finish;
  end

endmodule

[files.f]
design/ase_pkg.sv
design/ase_ram.sv
design/arm_subset_execute_unit.sv
bench/testbench.sv
